// ===== rtl/hvb_pkg.sv =====
package hvb_pkg;

   // Defaults for the top level parameters
   localparam int WORD_BITS_DEF  = 32;
   localparam int WORDS_DEF      = 256;
   localparam int COUNT_BITS_DEF = 16;

   // Fixed field widths of the request and result ports
   localparam int OP_BITS    = 2;
   localparam int INDEX_BITS = 8;
   localparam int DATA_BITS  = 32;

   typedef enum logic [OP_BITS-1:0] {
      OP_ACCUMULATE = 2'd0,
      OP_READ       = 2'd1,
      OP_CLEAR      = 2'd2
   } op_type;

   typedef enum logic {
      STATE_CLEAR = 1'b0,
      STATE_RUN   = 1'b1
   } state_type;

   // Control of the request in the read-modify-write stage
   typedef struct packed {
      logic   valid;
      logic   in_range;
      op_type op;
   } stage_ctl_type;

endpackage

// ===== rtl/hvb_ram.sv =====
module hvb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hvb_update.sv =====
module hvb_update #(
   parameter int WORD_BITS  = hvb_pkg::WORD_BITS_DEF,
   parameter int COUNT_BITS = hvb_pkg::COUNT_BITS_DEF,
   localparam int ROW_WIDTH = WORD_BITS * COUNT_BITS
) (
   input  hvb_pkg::op_type         op,
   input  logic [ROW_WIDTH-1:0]    row_in,
   input  logic [WORD_BITS-1:0]    vote_data,
   output logic [ROW_WIDTH-1:0]    row_out,
   output logic [WORD_BITS-1:0]    majority
);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

   // One saturating up/down counter per bit lane
   always_comb begin
      logic [COUNT_BITS-1:0] cnt;
      logic [COUNT_BITS-1:0] nxt;
      for (int j = 0; j < WORD_BITS; j++) begin
         cnt = row_in[j*COUNT_BITS +: COUNT_BITS];
         nxt = cnt;
         case (op)
            hvb_pkg::OP_ACCUMULATE: begin
               if (vote_data[j]) begin
                  if (cnt != CNT_MIN) nxt = cnt - 1'b1;
               end else begin
                  if (cnt != CNT_MAX) nxt = cnt + 1'b1;
               end
            end
            hvb_pkg::OP_CLEAR: nxt = '0;
            default:           nxt = cnt;
         endcase
         row_out[j*COUNT_BITS +: COUNT_BITS] = nxt;
         majority[j] = cnt[COUNT_BITS-1];
      end
   end

endmodule

// ===== rtl/hypervector_bundling_core.sv =====
// Hypervector bundling core: bitwise majority vote over WORDS words of WORD_BITS
// bits, one signed saturating COUNT_BITS counter per bit. The counters of one
// word form one row of a single synchronous RAM. After reset the core runs a
// clearing pass over all WORDS rows (busy high, no request taken); then busy
// stays low and a request is taken in every cycle. Each request reads its row
// at acceptance; the modify stage updates the row and writes it back. A
// back-to-back request to the same row is served from a forwarding register.
// A read request puts its majority word on the result ports, through the
// modify stage and the result register, for one cycle, with strobe high. The
// receiver cannot stall: results must be taken when strobe is high.
// Accumulate and clear requests give no result, nor does op code 3. Word
// indexes at or beyond WORDS change nothing; a read of one returns a zero word.
module hypervector_bundling_core #(
   parameter int WORD_BITS  = hvb_pkg::WORD_BITS_DEF,
   parameter int WORDS      = hvb_pkg::WORDS_DEF,
   parameter int COUNT_BITS = hvb_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           start,
   output logic                           busy,
   input  logic [hvb_pkg::OP_BITS-1:0]    req_op,
   input  logic [hvb_pkg::INDEX_BITS-1:0] req_word_index,
   input  logic [hvb_pkg::DATA_BITS-1:0]  req_word_data,
   // result channel
   output logic                           strobe,
   output logic [hvb_pkg::INDEX_BITS-1:0] rsp_result_index,
   output logic [hvb_pkg::DATA_BITS-1:0]  rsp_result_word
);

   localparam int ROW_BITS  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int ROW_WIDTH = WORD_BITS * COUNT_BITS;
   localparam int EXT_BITS  = (WORD_BITS > hvb_pkg::DATA_BITS) ? WORD_BITS
                                                                : hvb_pkg::DATA_BITS;
   localparam int IDX_EXT   = hvb_pkg::INDEX_BITS + ROW_BITS;

   // ---------------- control state ----------------
   hvb_pkg::state_type state_ff, state_in;
   logic [ROW_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic                clr_last;
   logic                clearing;
   logic                accept;

   // ---------------- request decode ----------------
   logic [IDX_EXT-1:0]   req_idx_ext;
   logic [ROW_BITS-1:0]  req_row;
   logic                 req_in_range;
   logic [EXT_BITS-1:0]  req_data_ext;

   // ---------------- modify stage ----------------
   hvb_pkg::stage_ctl_type s1_ctl_ff, s1_ctl_in;
   logic [hvb_pkg::INDEX_BITS-1:0] s1_index_ff;
   logic [ROW_BITS-1:0]            s1_row_ff;
   logic [WORD_BITS-1:0]           s1_data_ff;

   // ---------------- write-back / forwarding ----------------
   logic                 wb_valid_ff, wb_valid_in;
   logic [ROW_BITS-1:0]  wb_row_ff;
   logic [ROW_WIDTH-1:0] wb_data_ff;

   // ---------------- RAM ports ----------------
   logic                 ram_wr_en;
   logic [ROW_BITS-1:0]  ram_wr_addr;
   logic [ROW_WIDTH-1:0] ram_wr_data;
   logic [ROW_WIDTH-1:0] ram_rd_data;

   logic [ROW_WIDTH-1:0] row_cur;
   logic [ROW_WIDTH-1:0] row_new;
   logic [WORD_BITS-1:0] majority;
   logic [EXT_BITS-1:0]  majority_ext;
   logic                 item_write;

   // ---------------- result registers ----------------
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [hvb_pkg::INDEX_BITS-1:0] rsp_index_ff;
   logic [hvb_pkg::DATA_BITS-1:0]  rsp_word_ff;

   // ---- state machine: clearing pass after reset, then run ----
   assign clr_last = (clr_cnt_ff == ROW_BITS'(WORDS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hvb_pkg::STATE_CLEAR: if (clr_last) state_in = hvb_pkg::STATE_RUN;
         hvb_pkg::STATE_RUN:   state_in = hvb_pkg::STATE_RUN;
         default:              state_in = hvb_pkg::STATE_CLEAR;
      endcase
   end

   always_comb begin
      clearing = 1'b0;
      unique case (state_ff)
         hvb_pkg::STATE_CLEAR: clearing = 1'b1;
         hvb_pkg::STATE_RUN:   clearing = 1'b0;
         default:              clearing = 1'b1;
      endcase
   end

   assign clr_cnt_in = clearing ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign busy       = clearing;
   assign accept     = start & ~clearing;

   // ---- request decode ----
   assign req_idx_ext  = IDX_EXT'(req_word_index);
   assign req_row      = req_idx_ext[ROW_BITS-1:0];
   assign req_in_range = (32'(req_word_index) < 32'(WORDS));
   assign req_data_ext = EXT_BITS'(req_word_data);

   always_comb begin
      s1_ctl_in.valid    = accept;
      s1_ctl_in.in_range = req_in_range;
      s1_ctl_in.op       = hvb_pkg::op_type'(req_op);
   end

   // ---- counter RAM: one row of counters per word ----
   hvb_ram #(
      .WIDTH (ROW_WIDTH),
      .DEPTH (WORDS)
   ) u_counters (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (req_row),
      .rd_data (ram_rd_data)
   );

   // Row written at the last edge is not yet in the read data: forward it
   assign row_cur = (wb_valid_ff && (wb_row_ff == s1_row_ff)) ? wb_data_ff : ram_rd_data;

   hvb_update #(
      .WORD_BITS  (WORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_update (
      .op        (s1_ctl_ff.op),
      .row_in    (row_cur),
      .vote_data (s1_data_ff),
      .row_out   (row_new),
      .majority  (majority)
   );

   // Accumulate and clear write back; op code 3 and reads leave the row alone
   always_comb begin
      item_write = 1'b0;
      if (s1_ctl_ff.valid && s1_ctl_ff.in_range) begin
         case (s1_ctl_ff.op)
            hvb_pkg::OP_ACCUMULATE,
            hvb_pkg::OP_CLEAR: item_write = 1'b1;
            default:           item_write = 1'b0;
         endcase
      end
   end

   always_comb begin
      if (clearing) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = item_write;
         ram_wr_addr = s1_row_ff;
         ram_wr_data = row_new;
      end
   end

   assign wb_valid_in = item_write & ~clearing;

   // ---- result ----
   assign majority_ext = EXT_BITS'(majority);
   assign rsp_valid_in = s1_ctl_ff.valid && (s1_ctl_ff.op == hvb_pkg::OP_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hvb_pkg::STATE_CLEAR;
         clr_cnt_ff   <= '0;
         s1_ctl_ff    <= '0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_ctl_ff    <= s1_ctl_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_index_ff  <= req_word_index;
      s1_row_ff    <= req_row;
      s1_data_ff   <= req_data_ext[WORD_BITS-1:0];
      wb_row_ff    <= s1_row_ff;
      wb_data_ff   <= row_new;
      rsp_index_ff <= s1_index_ff;
      rsp_word_ff  <= s1_ctl_ff.in_range ? majority_ext[hvb_pkg::DATA_BITS-1:0] : '0;
   end

   assign strobe           = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_word  = rsp_word_ff;

endmodule
